[rtl/servo_hardstop_homing_sequencer_assert.svh]
// Assertion macros used by the checker file of the homing sequencer.
`ifndef SERVO_HARDSTOP_HOMING_SEQUENCER_ASSERT_SVH
`define SERVO_HARDSTOP_HOMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define SHHS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("homing sequencer check failed");

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define SHHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("homing sequencer check failed");

`endif

[rtl/shhs_pkg.sv]
package shhs_pkg;

    localparam int AXIS_COUNT_DEF = 4;
    // The axis field is two bits wide, so no more than four entries are ever addressed.
    localparam int AXIS_SLOTS   = 4;

    localparam logic [15:0] POWER_OFF_TICKS_RST = 16'd10;
    localparam logic [15:0] POWER_ON_TICKS_RST  = 16'd10;
    localparam logic [15:0] STALL_TICKS_RST     = 16'd1000;
    localparam logic [15:0] SETTLE_TICKS_RST    = 16'd10;
    localparam logic [15:0] TRIGGER_TICKS_RST   = 16'd500;
    localparam logic [15:0] HOMING_SPEED_RST    = 16'd5;

    typedef enum logic [3:0] {
        ST_UNPOWERED = 4'd0,
        ST_POWERED   = 4'd1,
        ST_PC_OFF    = 4'd2,
        ST_PC_ON     = 4'd3,
        ST_BEGIN     = 4'd4,
        ST_HOMING    = 4'd5,
        ST_STOP      = 4'd6,
        ST_HOMED     = 4'd7,
        ST_READY     = 4'd8
    } t_state;

    typedef enum logic [2:0] {
        REG_POWER_OFF_TICKS = 3'd0,
        REG_POWER_ON_TICKS  = 3'd1,
        REG_STALL_TICKS     = 3'd2,
        REG_SETTLE_TICKS    = 3'd3,
        REG_TRIGGER_TICKS   = 3'd4,
        REG_HOMING_SPEED    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_state      state;
        logic [15:0] ticks;
        logic [15:0] zf_ticks;
    } t_entry;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

[rtl/servo_hardstop_homing_sequencer.sv]
// Each in-range tick passes through stage 1 and then the output register; ticks for an axis
// at or above AXIS_COUNT give no result. Throughput: one tick per cycle for any mix of axes
// unless the output stalls; the per-axis state memory is read in the accept cycle and written
// back as the tick leaves stage 1, with a bypass for back-to-back ticks of the same axis.
// Reset: synchronous; all axes read as unpowered with zero counters and the
// registers take their default values, with no clearing pass.
module servo_hardstop_homing_sequencer #(
    parameter int AXIS_COUNT = shhs_pkg::AXIS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_axis,
    input  logic               i_machine_on,
    input  logic               i_start_homing,
    input  logic signed [15:0] i_feedback,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_axis_out,
    output logic [3:0]         o_seq_state,
    output logic               o_motor_enable,
    output logic               o_homing_busy,
    output logic               o_moving_flag,
    output logic               o_homed_flag,
    output logic               o_home_trigger,
    output logic [15:0]        o_speed_out,
    output logic               o_clear_request,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import shhs_pkg::*;

    localparam int DEPTH = (AXIS_COUNT < AXIS_SLOTS) ? AXIS_COUNT : AXIS_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0] r_power_off_ticks;
    logic [15:0] r_power_on_ticks;
    logic [15:0] r_stall_ticks;
    logic [15:0] r_settle_ticks;
    logic [15:0] r_trigger_ticks;
    logic [15:0] r_homing_speed;

    t_entry            mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    t_entry            r_rd_data;
    logic              r_rd_vld;
    logic              r_byp;
    t_entry            r_byp_data;

    logic              r_s1_valid;
    logic [AW-1:0]     r_s1_idx;
    logic [1:0]        r_s1_axis;
    logic              r_s1_on;
    logic              r_s1_req;
    logic              r_s1_fbz;

    logic              r_out_valid;

    logic              w_accept;
    logic              w_s1_go;
    logic              w_in_range;
    logic [AW-1:0]     w_idx;
    t_entry            w_cur;
    t_entry            n_entry;
    t_state            w_nxt;
    logic [15:0]       w_zf;

    logic              n_en;
    logic              n_busy;
    logic              n_mov;
    logic              n_hmd;
    logic              n_trg;
    logic [15:0]       n_spd;
    logic              n_clr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_off_ticks <= POWER_OFF_TICKS_RST;
            r_power_on_ticks  <= POWER_ON_TICKS_RST;
            r_stall_ticks     <= STALL_TICKS_RST;
            r_settle_ticks    <= SETTLE_TICKS_RST;
            r_trigger_ticks   <= TRIGGER_TICKS_RST;
            r_homing_speed    <= HOMING_SPEED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_POWER_OFF_TICKS: r_power_off_ticks <= i_cfg_data;
                REG_POWER_ON_TICKS:  r_power_on_ticks  <= i_cfg_data;
                REG_STALL_TICKS:     r_stall_ticks     <= i_cfg_data;
                REG_SETTLE_TICKS:    r_settle_ticks    <= i_cfg_data;
                REG_TRIGGER_TICKS:   r_trigger_ticks   <= i_cfg_data;
                REG_HOMING_SPEED:    r_homing_speed    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1 moves into the output register whenever that register is empty or being taken.
    assign w_s1_go    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !w_s1_go;
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (32'(i_axis) < AXIS_COUNT);
    assign w_idx      = i_axis[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            mem[r_s1_idx] <= n_entry;
        end
        if (w_accept) begin
            r_rd_data <= mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_vld   <= 1'b0;
            r_byp      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_s1_go) begin
                r_vld[r_s1_idx] <= 1'b1;
            end
            if (w_accept) begin
                r_rd_vld   <= r_vld[w_idx];
                // The memory read in this cycle misses the write-back happening at the same edge.
                r_byp      <= w_s1_go && (r_s1_idx == w_idx);
                r_s1_valid <= w_in_range;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byp_data <= n_entry;
            r_s1_idx   <= w_idx;
            r_s1_axis  <= i_axis;
            r_s1_on    <= i_machine_on;
            r_s1_req   <= i_start_homing;
            r_s1_fbz   <= (i_feedback == 16'sd0);
        end
    end

    always_comb begin
        if (r_byp) begin
            w_cur = r_byp_data;
        end else if (r_rd_vld) begin
            w_cur = r_rd_data;
        end else begin
            w_cur = '0;
        end
    end

    always_comb begin
        w_nxt = w_cur.state;
        w_zf  = w_cur.zf_ticks;
        if (!r_s1_on) begin
            w_nxt = ST_UNPOWERED;
        end else begin
            unique case (w_cur.state)
                ST_UNPOWERED: w_nxt = ST_POWERED;
                ST_POWERED, ST_READY: begin
                    if (r_s1_req) w_nxt = ST_PC_OFF;
                end
                ST_PC_OFF: begin
                    if (w_cur.ticks >= r_power_off_ticks) begin
                        w_nxt = ST_PC_ON;
                        w_zf  = '0;
                    end
                end
                ST_PC_ON: begin
                    if (w_cur.ticks >= r_power_on_ticks) w_nxt = ST_BEGIN;
                end
                ST_BEGIN: w_nxt = ST_HOMING;
                ST_HOMING: begin
                    if (w_cur.zf_ticks >= r_stall_ticks) w_nxt = ST_STOP;
                end
                ST_STOP: begin
                    if (w_cur.ticks >= r_settle_ticks) w_nxt = ST_HOMED;
                end
                ST_HOMED: begin
                    if (w_cur.ticks >= r_trigger_ticks) w_nxt = ST_READY;
                end
                default: w_nxt = ST_UNPOWERED;
            endcase
        end

        if (w_nxt == ST_HOMING) begin
            w_zf = r_s1_fbz ? sat_inc(w_zf) : 16'd0;
        end

        n_entry.state    = w_nxt;
        n_entry.ticks    = (w_nxt != w_cur.state) ? 16'd0 : sat_inc(w_cur.ticks);
        n_entry.zf_ticks = w_zf;

        n_en   = 1'b0;
        n_busy = 1'b0;
        n_mov  = 1'b0;
        n_hmd  = 1'b0;
        n_trg  = 1'b0;
        n_spd  = 16'd0;
        n_clr  = 1'b0;
        unique case (w_nxt)
            ST_POWERED: n_en = 1'b1;
            ST_PC_OFF: begin
                n_busy = 1'b1;
                n_clr  = 1'b1;
            end
            ST_PC_ON: begin
                n_en   = 1'b1;
                n_busy = 1'b1;
            end
            ST_BEGIN, ST_HOMING: begin
                n_en   = 1'b1;
                n_busy = 1'b1;
                n_mov  = 1'b1;
                n_spd  = r_homing_speed;
            end
            ST_STOP: begin
                n_en   = 1'b1;
                n_busy = 1'b1;
            end
            ST_HOMED: begin
                n_en  = 1'b1;
                n_trg = 1'b1;
            end
            ST_READY: begin
                n_en  = 1'b1;
                n_hmd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            o_axis_out      <= r_s1_axis;
            o_seq_state     <= w_nxt;
            o_motor_enable  <= n_en;
            o_homing_busy   <= n_busy;
            o_moving_flag   <= n_mov;
            o_homed_flag    <= n_hmd;
            o_home_trigger  <= n_trg;
            o_speed_out     <= n_spd;
            o_clear_request <= n_clr;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/shhs_check.sv]
`include "servo_hardstop_homing_sequencer_assert.svh"

module shhs_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic [1:0]  o_axis_out,
    input logic [3:0]  o_seq_state,
    input logic        o_motor_enable,
    input logic        o_homing_busy,
    input logic        o_moving_flag,
    input logic        o_homed_flag,
    input logic        o_home_trigger,
    input logic [15:0] o_speed_out,
    input logic        o_clear_request
);
    import shhs_pkg::*;

    // A result that is held back stays in place until it is taken.
    `SHHS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_seq_state) && $stable(o_axis_out))

    `SHHS_ASSERT_IMPL(a_speed_idle, o_valid && !o_moving_flag, o_speed_out == 16'd0)

    // Clearing the request happens only with the drive off in the power-cycle-off state.
    `SHHS_ASSERT_IMPL(a_clear_cycle, o_valid && o_clear_request, !o_motor_enable && o_homing_busy && (o_seq_state == ST_PC_OFF))

    `SHHS_ASSERT_IMPL(a_done_flags, o_valid && (o_homed_flag || o_home_trigger), o_motor_enable && !o_homing_busy && !(o_homed_flag && o_home_trigger))

endmodule

bind servo_hardstop_homing_sequencer shhs_check u_shhs_check (.*);
